[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds at an edge -> b holds at the same edge
`define KMP_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("kmp check failed");

// a holds at an edge -> b holds at the next edge
`define KMP_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("kmp check failed");

`endif

[sv/kmp_pkg.sv]
`default_nettype none
package kmp_pkg;

    localparam int OP_W         = 2;
    localparam int BYTE_W       = 8;
    localparam int WIN_W        = 20;
    localparam int MATCH_W      = 20;
    localparam int APB_DW       = 32;
    localparam int APB_AW       = 3;
    localparam int Q_DEPTH      = 2;
    localparam int PAT_MAX_DEF  = 64;
    localparam int POS_BITS_DEF = 20;

    localparam logic [WIN_W-1:0] WIN_LO_RST = '0;
    localparam logic [WIN_W-1:0] WIN_HI_RST = 20'hFFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_TEXT    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic {
        REG_WIN_LO = 1'b0,
        REG_WIN_HI = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        E_IDLE,
        E_LOAD,
        E_WALK,
        E_FIN
    } t_eng_state;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] byte_value;
    } t_cmd;

    typedef struct packed {
        logic [WIN_W-1:0] win_lo;
        logic [WIN_W-1:0] win_hi;
    } t_window;

endpackage
`default_nettype wire

[sv/kmp_stream_matcher.sv]
// Channel    Direction  Handshake              Beat
// command    in         push / full            i_opcode, i_byte_value
// match      out        pop / empty            o_match_start
// config     in / out   APB (psel, penable)    window start at 0x0, window end at 0x4
//
// Clear, restart, first and overflow pattern beats end in idle, as do text beats
// outside the window or with an empty pattern. Other pattern bytes pass load then walk,
// in-window text walks, repeated per failure step; a match adds fin (one read port).
// Reset is synchronous; it empties both queues, clears length, count and position and
// restores the window defaults; the pattern and failure stores hold no reset value.
// A text beat waits in the command queue while the match queue is full.
`default_nettype none
`include "assert_macros.svh"
module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX   = PAT_MAX_DEF,
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [OP_W-1:0]    i_opcode,
    input  wire logic [BYTE_W-1:0]  i_byte_value,
    output logic                    empty,
    input  wire logic               pop,
    output logic      [MATCH_W-1:0] o_match_start,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready
);

    t_window              r_win, n_win;
    t_reg_idx             reg_idx;
    logic                 cfg_wr;
    t_cmd                 cmd;
    logic                 cmd_valid, cmd_pop;
    logic                 res_push, res_full;
    logic [MATCH_W-1:0]   res_data;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        n_win = r_win;
        if (cfg_wr) begin
            case (reg_idx)
                REG_WIN_LO: n_win.win_lo = pwdata[WIN_W-1:0];
                REG_WIN_HI: n_win.win_hi = pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIN_LO: prdata = APB_DW'(r_win.win_lo);
            REG_WIN_HI: prdata = APB_DW'(r_win.win_hi);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.win_lo <= WIN_LO_RST;
            r_win.win_hi <= WIN_HI_RST;
        end else begin
            r_win <= n_win;
        end
    end

    kmp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_byte_value (i_byte_value),
        .o_cmd        (cmd),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_pop    (cmd_pop)
    );

    kmp_engine #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_win       (r_win),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res_data  (res_data)
    );

    kmp_fifo #(
        .WIDTH (MATCH_W),
        .DEPTH (Q_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_data),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (o_match_start),
        .o_empty (empty)
    );

    `KMP_ASSERT_IMP(a_push_room, i_clk, i_rst_n, res_push, !res_full)
    `KMP_ASSERT_IMP(a_pop_valid, i_clk, i_rst_n, cmd_pop, cmd_valid)
    `KMP_ASSERT_NXT(a_no_phantom, i_clk, i_rst_n, empty && !res_push, empty)

endmodule
`default_nettype wire

[sv/kmp_ram.sv]
`default_nettype none
module kmp_ram
    import kmp_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = PAT_MAX_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[sv/kmp_fifo.sv]
`default_nettype none
module kmp_fifo
    import kmp_pkg::*;
#(
    parameter int WIDTH = MATCH_W,
    parameter int DEPTH = Q_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_data[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (do_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_data[r_wp] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

[sv/kmp_front.sv]
`default_nettype none
module kmp_front
    import kmp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [BYTE_W-1:0] i_byte_value,
    output t_cmd                   o_cmd,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_pop
);

    t_cmd                     cmd_in;
    logic [$bits(t_cmd)-1:0]  q_rdata;
    logic                     q_empty;

    // opcode classification; byte only matters for pattern and text beats
    always_comb begin
        cmd_in.op         = t_op'(i_opcode);
        cmd_in.byte_value = i_byte_value;
        if (cmd_in.op == OP_CLEAR || cmd_in.op == OP_RESTART) begin
            cmd_in.byte_value = '0;
        end
    end

    kmp_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (Q_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (cmd_in),
        .o_full  (full),
        .i_rd    (i_cmd_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign o_cmd       = t_cmd'(q_rdata);
    assign o_cmd_valid = !q_empty;

endmodule
`default_nettype wire

[sv/kmp_engine.sv]
`default_nettype none
module kmp_engine
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX   = PAT_MAX_DEF,
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic               i_cmd_valid,
    output logic                    o_cmd_pop,
    input  wire t_window            i_win,
    input  wire logic               i_res_full,
    output logic                    o_res_push,
    output logic      [MATCH_W-1:0] o_res_data
);

    localparam int IDX_W  = $clog2(PATTERN_MAX);
    localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
    localparam int WIDE_W = (POSITION_BITS > WIN_W) ? POSITION_BITS : WIN_W;

    t_eng_state               r_state, n_state;
    logic [CNT_W-1:0]         r_len, n_len;
    logic [CNT_W-1:0]         r_mc, n_mc;
    logic [CNT_W-1:0]         r_k, n_k;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_cur_pos, n_cur_pos;
    logic [BYTE_W-1:0]        r_char, n_char;
    logic                     r_is_text, n_is_text;

    logic                     pat_we, fail_we;
    logic [IDX_W-1:0]         pat_waddr, fail_waddr, pat_raddr, fail_raddr;
    logic [BYTE_W-1:0]        pat_wdata, pat_q;
    logic [IDX_W-1:0]         fail_wdata, fail_q;
    logic                     rd_len;

    logic                     cmd_go, in_win, pat_full, hit, step_back, full_match;
    logic [CNT_W-1:0]         k_adv, fail_ext, len_m1, k_m1;
    logic [WIDE_W-1:0]        pos_w, lo_w, hi_w, start_w;
    logic [POSITION_BITS-1:0] start_pos;

    assign cmd_go     = (r_state == E_IDLE) && i_cmd_valid
                        && !(i_cmd.op == OP_TEXT && i_res_full);
    assign pos_w      = WIDE_W'(r_pos);
    assign lo_w       = WIDE_W'(i_win.win_lo);
    assign hi_w       = WIDE_W'(i_win.win_hi);
    assign in_win     = (pos_w >= lo_w) && (pos_w < hi_w);
    assign pat_full   = (r_len == CNT_W'(PATTERN_MAX));
    assign hit        = (pat_q == r_char);
    assign step_back  = (r_k != '0) && !hit;
    assign k_adv      = r_k + CNT_W'(hit);
    assign fail_ext   = CNT_W'(fail_q);
    assign full_match = (k_adv == r_len);
    assign len_m1     = r_len - 1'b1;
    assign k_m1       = n_k - 1'b1;

    // start = position of last byte minus (length - 1), reported on 20 bits
    assign start_pos  = r_cur_pos - POSITION_BITS'(len_m1);
    assign start_w    = WIDE_W'(start_pos);
    assign o_res_data = start_w[MATCH_W-1:0];

    assign pat_raddr  = n_k[IDX_W-1:0];
    assign fail_raddr = rd_len ? len_m1[IDX_W-1:0] : k_m1[IDX_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE: begin
                if (cmd_go) begin
                    if (i_cmd.op == OP_PATTERN && !pat_full && r_len != '0) begin
                        n_state = E_LOAD;
                    end else if (i_cmd.op == OP_TEXT && r_len != '0 && in_win) begin
                        n_state = E_WALK;
                    end
                end
            end
            E_LOAD: n_state = E_WALK;
            E_WALK: begin
                if (!step_back) begin
                    n_state = (r_is_text && full_match) ? E_FIN : E_IDLE;
                end
            end
            E_FIN:   n_state = E_IDLE;
            default: n_state = E_IDLE;
        endcase
    end

    always_comb begin
        n_len      = r_len;
        n_mc       = r_mc;
        n_k        = r_k;
        n_pos      = r_pos;
        n_cur_pos  = r_cur_pos;
        n_char     = r_char;
        n_is_text  = r_is_text;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        pat_we     = 1'b0;
        pat_waddr  = r_len[IDX_W-1:0];
        pat_wdata  = r_char;
        fail_we    = 1'b0;
        fail_waddr = r_len[IDX_W-1:0];
        fail_wdata = k_adv[IDX_W-1:0];
        rd_len     = 1'b0;
        case (r_state)
            E_IDLE: begin
                if (cmd_go) begin
                    o_cmd_pop = 1'b1;
                    n_char    = i_cmd.byte_value;
                    n_is_text = (i_cmd.op == OP_TEXT);
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_len = '0;
                            n_mc  = '0;
                            n_pos = '0;
                        end
                        OP_RESTART: begin
                            n_mc  = '0;
                            n_pos = '0;
                        end
                        OP_PATTERN: begin
                            if (!pat_full) begin
                                pat_we    = 1'b1;
                                pat_wdata = i_cmd.byte_value;
                                if (r_len == '0) begin
                                    fail_we    = 1'b1;
                                    fail_wdata = '0;
                                    n_len      = CNT_W'(1);
                                end else begin
                                    rd_len = 1'b1;
                                end
                            end
                        end
                        OP_TEXT: begin
                            n_cur_pos = r_pos;
                            n_pos     = r_pos + 1'b1;
                            if (r_len != '0) begin
                                if (in_win) begin
                                    n_k = r_mc;
                                end else begin
                                    n_mc = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            E_LOAD: begin
                n_k = fail_ext;
            end
            E_WALK: begin
                if (step_back) begin
                    n_k = fail_ext;
                end else if (r_is_text) begin
                    if (full_match) begin
                        o_res_push = 1'b1;
                        rd_len     = 1'b1;
                    end else begin
                        n_mc = k_adv;
                    end
                end else begin
                    fail_we = 1'b1;
                    n_len   = r_len + 1'b1;
                end
            end
            E_FIN: begin
                n_mc = fail_ext;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_len   <= '0;
            r_mc    <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_mc    <= n_mc;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_cur_pos <= n_cur_pos;
        r_char    <= n_char;
        r_is_text <= n_is_text;
    end

    kmp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PATTERN_MAX)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (pat_waddr),
        .i_wdata (pat_wdata),
        .i_raddr (pat_raddr),
        .o_rdata (pat_q)
    );

    kmp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PATTERN_MAX)
    ) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (fail_we),
        .i_waddr (fail_waddr),
        .i_wdata (fail_wdata),
        .i_raddr (fail_raddr),
        .o_rdata (fail_q)
    );

endmodule
`default_nettype wire
